/* sv/qnc_pkg.sv */
package qnc_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int CODE_DIGITS = 16;
	localparam int WALK_LIMIT = (MAX_DEPTH < CODE_DIGITS) ? MAX_DEPTH : CODE_DIGITS;

	localparam int CODE_W = 2 * CODE_DIGITS;
	localparam int LEN_W = 5;
	localparam int MOVE_W = 3;
	localparam int STATE_W = 4;
	localparam int NUM_STATES = 9;
	localparam int SCAN_LEVELS = $clog2(CODE_DIGITS);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [MOVE_W-1:0] move_t;
	typedef logic [STATE_W-1:0] walk_state_t;
	typedef logic [1:0] digit_t;

	// state 8 = walk halted
	localparam walk_state_t HALT = 4'd8;

	// index = move * 4 + digit
	localparam digit_t WALK_DIGIT [32] = '{
		2'd1, 2'd0, 2'd3, 2'd2,  2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd3, 2'd0, 2'd1,  2'd2, 2'd3, 2'd0, 2'd1,
		2'd3, 2'd2, 2'd1, 2'd0,  2'd3, 2'd2, 2'd1, 2'd0,
		2'd3, 2'd2, 2'd1, 2'd0,  2'd3, 2'd2, 2'd1, 2'd0
	};

	localparam walk_state_t WALK_NEXT [32] = '{
		4'd8, 4'd0, 4'd8, 4'd0,  4'd1, 4'd8, 4'd1, 4'd8,
		4'd8, 4'd8, 4'd2, 4'd2,  4'd3, 4'd3, 4'd8, 4'd8,
		4'd3, 4'd4, 4'd8, 4'd0,  4'd8, 4'd0, 4'd2, 4'd5,
		4'd1, 4'd8, 4'd6, 4'd2,  4'd7, 4'd3, 4'd1, 4'd8
	};

endpackage

/* sv/qnc_channels.sv */
interface qnc_req_if;
	logic             valid;
	logic             ready;
	qnc_pkg::code_t   location_code;
	qnc_pkg::len_t    code_length;
	qnc_pkg::move_t   move_direction;

	modport source (output valid, output location_code, output code_length,
		output move_direction, input ready);
	modport sink (input valid, input location_code, input code_length,
		input move_direction, output ready);
endinterface

interface qnc_rsp_if;
	logic             valid;
	logic             ready;
	qnc_pkg::code_t   neighbor_code;
	logic             off_edge;

	modport source (output valid, output neighbor_code, output off_edge, input ready);
	modport sink (input valid, input neighbor_code, input off_edge, output ready);
endinterface

/* sv/qnc_walk.sv */
module qnc_walk (
	input  qnc_pkg::code_t location_code,
	input  qnc_pkg::len_t  code_length,
	input  qnc_pkg::move_t move_direction,
	output qnc_pkg::code_t neighbor_code,
	output logic           off_edge
);

	typedef logic [qnc_pkg::NUM_STATES-1:0][qnc_pkg::STATE_W-1:0] move_map_t;

	// r(x) = a(b(x)): b covers deeper digits
	function automatic move_map_t compose(move_map_t a, move_map_t b);
		move_map_t r;
		for (int x = 0; x < qnc_pkg::NUM_STATES; x++) begin
			r[x] = a[b[x]];
		end
		return r;
	endfunction

	qnc_pkg::len_t       eff_len;
	qnc_pkg::walk_state_t start_state;
	move_map_t           maps [qnc_pkg::SCAN_LEVELS+1][qnc_pkg::CODE_DIGITS];
	qnc_pkg::walk_state_t enter_state [qnc_pkg::CODE_DIGITS];

	assign eff_len = (code_length > qnc_pkg::LEN_W'(qnc_pkg::WALK_LIMIT))
		? qnc_pkg::LEN_W'(qnc_pkg::WALK_LIMIT) : code_length;
	assign start_state = {1'b0, move_direction};

	// per-digit transfer maps, then suffix scan from the deepest digit up
	always_comb begin
		for (int i = 0; i < qnc_pkg::CODE_DIGITS; i++) begin
			for (int x = 0; x < qnc_pkg::NUM_STATES; x++) begin
				if ((qnc_pkg::LEN_W'(i) >= eff_len) || (x == int'(qnc_pkg::HALT))) begin
					maps[0][i][x] = qnc_pkg::STATE_W'(x);
				end else begin
					maps[0][i][x] = qnc_pkg::WALK_NEXT[{qnc_pkg::MOVE_W'(x),
						location_code[2*i +: 2]}];
				end
			end
		end
		for (int l = 0; l < qnc_pkg::SCAN_LEVELS; l++) begin
			for (int i = 0; i < qnc_pkg::CODE_DIGITS; i++) begin
				if (i + (1 << l) < qnc_pkg::CODE_DIGITS) begin
					maps[l+1][i] = compose(maps[l][i], maps[l][i + (1 << l)]);
				end else begin
					maps[l+1][i] = maps[l][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < qnc_pkg::CODE_DIGITS; i++) begin
			if (i == qnc_pkg::CODE_DIGITS - 1) begin
				enter_state[i] = start_state;
			end else begin
				enter_state[i] = maps[qnc_pkg::SCAN_LEVELS][i+1][start_state];
			end
			if ((qnc_pkg::LEN_W'(i) < eff_len) && (enter_state[i] != qnc_pkg::HALT)) begin
				neighbor_code[2*i +: 2] = qnc_pkg::WALK_DIGIT[{enter_state[i][2:0],
					location_code[2*i +: 2]}];
			end else begin
				neighbor_code[2*i +: 2] = location_code[2*i +: 2];
			end
		end
	end

	assign off_edge = (maps[qnc_pkg::SCAN_LEVELS][0][start_state] != qnc_pkg::HALT);

endmodule

/* sv/quadtree_neighbor_code_unit.sv */
// channel | dir | payload                                        | word accepted
// req     | in  | location_code[32] code_length[5] move_direction[3] | valid && ready
// rsp     | out | neighbor_code[32] off_edge[1]                  | valid && ready
//
// One word per cycle sustained while rsp is ready; a stalled rsp holds the flow.
// Input register, one combinational pass (digit maps + 4-level suffix scan), result register.
// arst_n clears both stage valids; payload registers are not reset.
// A stalled rsp holds its word; req stays ready while the input stage is empty or can move.
module quadtree_neighbor_code_unit (
	input  logic      clk,
	input  logic      arst_n,
	qnc_req_if.sink   req,
	qnc_rsp_if.source rsp
);

	logic           valid_s1;
	qnc_pkg::code_t code_s1;
	qnc_pkg::len_t  len_s1;
	qnc_pkg::move_t move_s1;

	logic           valid_s2;
	qnc_pkg::code_t neighbor_s2;
	logic           off_s2;

	qnc_pkg::code_t walk_code;
	logic           walk_off;
	logic           adv_s1;

	assign adv_s1 = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			code_s1 <= req.location_code;
			len_s1 <= req.code_length;
			move_s1 <= req.move_direction;
		end
	end

	qnc_walk u_walk (
		.location_code (code_s1),
		.code_length   (len_s1),
		.move_direction(move_s1),
		.neighbor_code (walk_code),
		.off_edge      (walk_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			neighbor_s2 <= walk_code;
			off_s2 <= walk_off;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.neighbor_code = neighbor_s2;
	assign rsp.off_edge = off_s2;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("req not ready with empty input stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted word lost from input stage");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> valid_s2)
		else $error("input stage word not passed to result register");

	a_zero_len_off_edge: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (len_s1 == '0) |-> walk_off && (walk_code == code_s1))
		else $error("zero-length walk must pass code and flag off edge");

endmodule

/* dv/quadtree_neighbor_code_unit_tb.sv */
`timescale 1ns / 100ps

module quadtree_neighbor_code_unit_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [3:0] {
		GO_R, GO_L, GO_D, GO_U, GO_RU, GO_RD, GO_LD, GO_LU, GO_STOP
	} walk_move_t;

	// rows by move, columns by quadrant digit
	localparam qnc_pkg::digit_t NEW_DIGIT [32] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd3, 2'd0, 2'd1,
		2'd2, 2'd3, 2'd0, 2'd1,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd3, 2'd2, 2'd1, 2'd0
	};

	localparam walk_move_t NEXT_MOVE [32] = '{
		GO_STOP, GO_R,    GO_STOP, GO_R,
		GO_L,    GO_STOP, GO_L,    GO_STOP,
		GO_STOP, GO_STOP, GO_D,    GO_D,
		GO_U,    GO_U,    GO_STOP, GO_STOP,
		GO_U,    GO_RU,   GO_STOP, GO_R,
		GO_STOP, GO_R,    GO_D,    GO_RD,
		GO_L,    GO_STOP, GO_LD,   GO_D,
		GO_LU,   GO_U,    GO_L,    GO_STOP
	};

	typedef struct packed {
		qnc_pkg::code_t loc;
		qnc_pkg::len_t  len;
		qnc_pkg::move_t dir;
		qnc_pkg::code_t code;
		logic           off;
	} neighbor_t;

	class neighbor_checker_t;
		neighbor_t expected_neighbors [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function neighbor_t walk_neighbor(qnc_pkg::code_t loc, qnc_pkg::len_t len,
			qnc_pkg::move_t dir);
			neighbor_t       n;
			walk_move_t      mv;
			qnc_pkg::digit_t dg;
			logic [4:0]      idx;
			logic            halted;
			int              depth;
			n.loc = loc;
			n.len = len;
			n.dir = dir;
			n.code = loc;
			mv = walk_move_t'({1'b0, dir});
			halted = 1'b0;
			depth = (int'(len) > qnc_pkg::WALK_LIMIT) ? qnc_pkg::WALK_LIMIT : int'(len);
			for (int k = depth - 1; k >= 0 && !halted; k--) begin
				dg = n.code[2*k +: 2];
				idx = {mv[2:0], dg};
				n.code[2*k +: 2] = NEW_DIGIT[idx];
				if (NEXT_MOVE[idx] == GO_STOP)
					halted = 1'b1;
				else
					mv = NEXT_MOVE[idx];
			end
			n.off = !halted;
			return n;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function void note_request(qnc_pkg::code_t loc, qnc_pkg::len_t len,
			qnc_pkg::move_t dir);
			expected_neighbors = {expected_neighbors, walk_neighbor(loc, len, dir)};
		endfunction

		task check_response(qnc_pkg::code_t code, logic off);
			neighbor_t e;
			if (expected_neighbors.size() == 0) begin
				report($sformatf("unexpected word code=%h off=%b", code, off));
			end else begin
				e = expected_neighbors.pop_front();
				if (code !== e.code)
					report($sformatf("loc=%h len=%0d dir=%0d: code %h, want %h",
						e.loc, e.len, e.dir, code, e.code));
				if (off !== e.off)
					report($sformatf("loc=%h len=%0d dir=%0d: off_edge %b, want %b",
						e.loc, e.len, e.dir, off, e.off));
			end
		endtask

		function int outstanding();
			return expected_neighbors.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle;
	int   sink_stall;
	int   idle_cycles;

	neighbor_checker_t sb = new();

	qnc_req_if req();
	qnc_rsp_if rsp();

	quadtree_neighbor_code_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.location_code, req.code_length, req.move_direction);
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.neighbor_code, rsp.off_edge);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
		rsp.ready <= ($urandom_range(0, 99) >= sink_stall);
	end

	task automatic send_word(qnc_pkg::code_t loc, qnc_pkg::len_t len, qnc_pkg::move_t dir);
		while ($urandom_range(0, 99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.location_code <= loc;
		req.code_length <= len;
		req.move_direction <= dir;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic directed_words();
		for (int d = 0; d < 8; d++)
			send_word(32'h1B1B_1B1B, qnc_pkg::len_t'(qnc_pkg::WALK_LIMIT), qnc_pkg::move_t'(d));
		// walks that run off the root square, then one that stays inside it
		send_word(32'h0000_0000, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_L));
		send_word(32'hFFFF_FFFF, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_R));
		send_word(32'hFFFF_FFFF, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_D));
		send_word(32'h0000_0000, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_U));
		send_word(32'h0000_0001, qnc_pkg::len_t'(1), qnc_pkg::move_t'(GO_R));
		send_word(32'h0000_0000, qnc_pkg::len_t'(1), qnc_pkg::move_t'(GO_R));
		// zero and oversized lengths, then diagonal moves at full length
		send_word(32'hA5C3_3C5A, qnc_pkg::len_t'(0), qnc_pkg::move_t'(GO_D));
		send_word(32'hFFFF_FFFF, qnc_pkg::len_t'(17), qnc_pkg::move_t'(GO_LU));
		send_word(32'h0000_0000, qnc_pkg::len_t'(31), qnc_pkg::move_t'(GO_RD));
		send_word(32'h5555_5555, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_LD));
		send_word(32'hAAAA_AAAA, qnc_pkg::len_t'(16), qnc_pkg::move_t'(GO_RU));
	endtask

	task automatic random_word();
		qnc_pkg::code_t  loc;
		qnc_pkg::len_t   len;
		qnc_pkg::digit_t dg;
		int              pos;
		if ($urandom_range(0, 9) < 6) begin
			loc = $urandom();
		end else begin
			// uniform digits, with one digit changed, can keep the walk going toward the root
			dg = qnc_pkg::digit_t'($urandom_range(0, 3));
			loc = {16{dg}};
			pos = int'($urandom_range(0, 15));
			loc[2*pos +: 2] = 2'($urandom_range(0, 3));
		end
		case ($urandom_range(0, 19))
			0: len = '0;
			1: len = qnc_pkg::len_t'($urandom_range(17, 31));
			2, 3: len = qnc_pkg::len_t'(qnc_pkg::WALK_LIMIT);
			default: len = qnc_pkg::len_t'($urandom_range(1, 16));
		endcase
		send_word(loc, len, qnc_pkg::move_t'($urandom_range(0, 7)));
	endtask

	task automatic run_phase(int src, int snk, int count);
		src_idle = src;
		sink_stall = snk;
		repeat (count)
			random_word();
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		src_idle = 0;
		sink_stall = 0;
		req.valid = 1'b0;
		req.location_code = '0;
		req.code_length = '0;
		req.move_direction = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();
		wait_drained();

		run_phase(0, 0, 425);
		run_phase(49, 0, 425);
		run_phase(0, 49, 425);
		run_phase(36, 36, 425);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
